// File: design/gmi5_pkg.sv
// Package for the 5-D grid interpolator: shared types, constants, field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gmi5_pkg;
    localparam int AXES = 5;
    localparam int ADDR_W = 15;
    localparam int VAL_W = 16;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DEF_POINTS = 8;
    localparam int FRAC_W = 17;
    localparam int CELL_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS4 = 3'd4;
    localparam logic [CFG_W-1:0] GRID_RESET = 32'h0000_0100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_READ,
        ST_BLEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic write_entry;
        logic load_query;
        logic locate;
        logic read_corner;
        logic blend_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic reads_done;
        logic blend_done;
    } dp_status_t;
endpackage
`default_nettype wire

// File: design/gmi5_ctrl.sv
// Controller FSM for the 5-D grid interpolator.
// Depends on gmi5_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmi5_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              kind,
    input  wire gmi5_pkg::dp_status_t status,
    output gmi5_pkg::dp_cmd_t      cmd,
    output logic                   busy
);
    import gmi5_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && kind)
                begin
                    state_next = ST_LOCATE;
                end
            end
            ST_LOCATE: state_next = ST_READ;
            ST_READ:
            begin
                if (status.reads_done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (status.blend_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.write_entry = start && !kind;
                cmd.load_query = start && kind;
            end
            ST_LOCATE: cmd.locate = 1'b1;
            ST_READ: cmd.read_corner = 1'b1;
            ST_BLEND: cmd.blend_step = 1'b1;
            ST_DONE: cmd.emit = 1'b1;
            default: busy = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

// File: design/gmi5_dp.sv
// Datapath for the 5-D grid interpolator: axis locate, table memory, blend unit.
// Depends on gmi5_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmi5_dp #(
    parameter int POINTS_AXIS0 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS1 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS2 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS3 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS4 = gmi5_pkg::DEF_POINTS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gmi5_pkg::dp_cmd_t                 cmd,
    output gmi5_pkg::dp_status_t                   status,
    input  wire logic [gmi5_pkg::ADDR_W-1:0]       entry_address,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] entry_value,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a0,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a1,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a2,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a3,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_w,
    input  wire logic [gmi5_pkg::AXES-1:0][gmi5_pkg::CFG_W-1:0] grid,
    output logic                                   valid,
    output logic signed [gmi5_pkg::VAL_W-1:0]      interp_value,
    output logic                                   out_of_range
);
    import gmi5_pkg::*;

    localparam int PTS [AXES] = '{POINTS_AXIS0, POINTS_AXIS1, POINTS_AXIS2,
                                  POINTS_AXIS3, POINTS_AXIS4};
    localparam int DEPTH = 1 << ADDR_W;

    logic [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] coord_reg [AXES];
    logic [CELL_W-1:0] cell_reg [AXES];
    logic [FRAC_W-1:0] frac_reg [AXES];
    logic oor_reg;
    logic [5:0] rd_cnt_reg;
    logic rd_valid_reg;
    logic [4:0] wr_idx_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic signed [VAL_W-1:0] vals_reg [32];
    logic [4:0] bl_idx_reg;
    logic [2:0] bl_lvl_reg;
    logic [4:0] bl_n;
    logic valid_reg;
    logic signed [VAL_W-1:0] out_val_reg;
    logic out_oor_reg;

    // axis locate
    logic [CELL_W-1:0] cell_c [AXES];
    logic [FRAC_W-1:0] frac_c [AXES];
    logic [AXES-1:0] bad_c;
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            logic signed [VAL_W:0] d;
            logic [VAL_W-1:0] rcp;
            logic [32:0] t;
            logic [32:0] top;
            d = 17'(coord_reg[a]) - 17'($signed(grid[a][31:16]));
            rcp = grid[a][15:0];
            t = 33'(d[VAL_W-1:0]) * 33'(rcp);
            top = 33'(PTS[a] - 1) << 16;
            bad_c[a] = d[VAL_W] || (t > top);
            if (t == top)
            begin
                cell_c[a] = CELL_W'(PTS[a] - 2);
                frac_c[a] = FRAC_W'(1 << 16);
            end
            else
            begin
                cell_c[a] = t[16 +: CELL_W];
                frac_c[a] = {1'b0, t[15:0]};
            end
        end
    end

    // corner address, k = rd_cnt bits: bit4 axis0 ... bit0 w
    logic [ADDR_W-1:0] rd_addr;
    always_comb
    begin
        logic [31:0] acc;
        acc = '0;
        for (int a = 0; a < AXES; a++)
        begin
            acc = acc * 32'(PTS[a]) + 32'(cell_reg[a]) + 32'(rd_cnt_reg[4-a]);
        end
        rd_addr = acc[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            mem[entry_address] <= entry_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // blend unit
    logic signed [VAL_W-1:0] v0, v1, bl_res;
    logic [FRAC_W-1:0] bl_f;
    always_comb
    begin
        logic signed [VAL_W:0] diff;
        logic signed [35:0] p;
        v0 = vals_reg[{bl_idx_reg[3:0], 1'b0}];
        v1 = vals_reg[{bl_idx_reg[3:0], 1'b1}];
        bl_f = frac_reg[3'(4 - bl_lvl_reg)];
        diff = 17'(v1) - 17'(v0);
        p = 36'(diff) * $signed({19'd0, bl_f}) + 36'sd32768;
        bl_res = v0 + VAL_W'(p >>> 16);
    end
    assign bl_n = 5'd16 >> bl_lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            valid_reg <= 1'b0;
            bl_idx_reg <= '0;
            bl_lvl_reg <= '0;
            wr_idx_reg <= '0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            rd_valid_reg <= cmd.read_corner && !rd_cnt_reg[5];
            wr_idx_reg <= rd_cnt_reg[4:0];
            if (cmd.locate)
            begin
                rd_cnt_reg <= '0;
                bl_idx_reg <= '0;
                bl_lvl_reg <= '0;
            end
            else if (cmd.read_corner && !rd_cnt_reg[5])
            begin
                rd_cnt_reg <= rd_cnt_reg + 6'd1;
            end
            if (cmd.blend_step)
            begin
                if (bl_idx_reg == bl_n - 5'd1)
                begin
                    bl_idx_reg <= '0;
                    bl_lvl_reg <= bl_lvl_reg + 3'd1;
                end
                else
                begin
                    bl_idx_reg <= bl_idx_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            coord_reg[0] <= coord_a0;
            coord_reg[1] <= coord_a1;
            coord_reg[2] <= coord_a2;
            coord_reg[3] <= coord_a3;
            coord_reg[4] <= coord_w;
        end
        if (cmd.locate)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cell_reg[a] <= cell_c[a];
                frac_reg[a] <= frac_c[a];
            end
            oor_reg <= |bad_c;
        end
        if (rd_valid_reg)
        begin
            vals_reg[wr_idx_reg] <= rd_data_reg;
        end
        if (cmd.blend_step)
        begin
            vals_reg[bl_idx_reg] <= bl_res;
        end
        if (cmd.emit)
        begin
            out_val_reg <= oor_reg ? '0 : vals_reg[0];
            out_oor_reg <= oor_reg;
        end
    end

    assign status.reads_done = rd_cnt_reg[5] && !rd_valid_reg;
    assign status.blend_done = cmd.blend_step && (bl_lvl_reg == 3'd4);
    assign valid = valid_reg;
    assign interp_value = out_val_reg;
    assign out_of_range = out_oor_reg;
endmodule
`default_nettype wire

// File: design/grid_multilinear_interp_5d.sv
// Top level of the 5-D grid interpolator: config registers, controller, datapath.
// Depends on gmi5_pkg, gmi5_ctrl, gmi5_dp.
`timescale 1ns / 1ps
`default_nettype none
// A table write leaves busy low and gives no word back. A query goes from the accepting
// edge to the done strobe in these steps: locate the cell on all five axes, read
// the 32 corner words through the single registered table read port, 31 blend steps on
// the one shared interpolation unit, and register the word. busy is high for the whole
// query and drops as done rises, so the next word can be started in the done cycle.
// The word sits on interp_value/out_of_range for the single cycle done is high;
// the receiver cannot stall it. Table entries read before being written are undefined.
module grid_multilinear_interp_5d #(
    parameter int POINTS_AXIS0 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS1 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS2 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS3 = gmi5_pkg::DEF_POINTS,
    parameter int POINTS_AXIS4 = gmi5_pkg::DEF_POINTS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              kind,
    input  wire logic [gmi5_pkg::ADDR_W-1:0]       entry_address,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] entry_value,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a0,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a1,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a2,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_a3,
    input  wire logic signed [gmi5_pkg::VAL_W-1:0] coord_w,
    input  wire logic                              cfg_we,
    input  wire logic [gmi5_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gmi5_pkg::CFG_W-1:0]        cfg_data,
    output logic                                   done,
    output logic signed [gmi5_pkg::VAL_W-1:0]      interp_value,
    output logic                                   out_of_range
);
    import gmi5_pkg::*;

    logic [AXES-1:0][CFG_W-1:0] grid_reg;
    dp_cmd_t cmd;
    dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                grid_reg[a] <= GRID_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS0: grid_reg[0] <= cfg_data;
                REG_AXIS1: grid_reg[1] <= cfg_data;
                REG_AXIS2: grid_reg[2] <= cfg_data;
                REG_AXIS3: grid_reg[3] <= cfg_data;
                REG_AXIS4: grid_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    gmi5_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    gmi5_dp #(
        .POINTS_AXIS0 (POINTS_AXIS0),
        .POINTS_AXIS1 (POINTS_AXIS1),
        .POINTS_AXIS2 (POINTS_AXIS2),
        .POINTS_AXIS3 (POINTS_AXIS3),
        .POINTS_AXIS4 (POINTS_AXIS4)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .coord_a0      (coord_a0),
        .coord_a1      (coord_a1),
        .coord_a2      (coord_a2),
        .coord_a3      (coord_a3),
        .coord_w       (coord_w),
        .grid          (grid_reg),
        .valid         (done),
        .interp_value  (interp_value),
        .out_of_range  (out_of_range)
    );
endmodule
`default_nettype wire

// File: design/gmi5_checker.sv
// Port-level checker for the 5-D grid interpolator, bound to the top level.
// Depends on grid_multilinear_interp_5d ports only.
`timescale 1ns / 1ps
`default_nettype none
module gmi5_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        kind,
    input wire logic        done,
    input wire logic [15:0] interp_value,
    input wire logic        out_of_range
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("done without busy");
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> interp_value == 16'd0) else $error("oor nonzero");
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !kind |=> !busy) else $error("write held busy");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind |=> busy) else $error("query not busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done too long");
endmodule

bind grid_multilinear_interp_5d gmi5_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .done         (done),
    .interp_value (interp_value),
    .out_of_range (out_of_range)
);
`default_nettype wire

// File: bench/grid_multilinear_interp_5d_test.sv
// Self-checking bench for grid_multilinear_interp_5d: table writes, 5-D queries, axis configs.
// Depends on gmi5_pkg and the grid_multilinear_interp_5d RTL; nothing else.
`timescale 1ns / 1ps
module grid_multilinear_interp_5d_test;
    import gmi5_pkg::*;

    localparam int NPTS = DEF_POINTS;
    localparam int PHASE_WORDS = 350;
    localparam int SETTLE = 45;

    typedef struct packed {
        logic kind;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0] value;
        logic [AXES-1:0][VAL_W-1:0] coord;
    } request_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic flag;
    } sample_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic kind = 0;
    logic [ADDR_W-1:0] entry_address = '0;
    logic signed [VAL_W-1:0] entry_value = '0;
    logic signed [VAL_W-1:0] coord_a0 = '0, coord_a1 = '0, coord_a2 = '0;
    logic signed [VAL_W-1:0] coord_a3 = '0, coord_w = '0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic busy, done, out_of_range;
    logic signed [VAL_W-1:0] interp_value;

    grid_multilinear_interp_5d uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .entry_address(entry_address), .entry_value(entry_value),
        .coord_a0(coord_a0), .coord_a1(coord_a1), .coord_a2(coord_a2),
        .coord_a3(coord_a3), .coord_w(coord_w),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .interp_value(interp_value), .out_of_range(out_of_range)
    );

    request_t request_q[$];
    sample_t expected_q[$];
    logic [CFG_W-1:0] grid_cfg [AXES];
    logic [VAL_W-1:0] table_model [1 << ADDR_W];
    bit written [1 << ADDR_W];
    request_t cur;
    int gap = 0;
    int errors = 0;
    int n_writes = 0, n_queries = 0, n_oor = 0, n_checked = 0;
    int phase_count;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("** grid_multilinear_interp_5d: FAILED **");
        $finish;
    end

    function automatic bit axis_locate(input logic [VAL_W-1:0] c, input logic [CFG_W-1:0] g,
                                       output int cidx, output longint frac);
        int d;
        longint t;
        longint top;
        d = int'($signed(c)) - int'($signed(g[31:16]));
        top = longint'(NPTS - 1) << 16;
        cidx = 0;
        frac = 0;
        if (d < 0)
            return 0;
        t = longint'(d) * longint'(g[15:0]);
        if (t > top)
            return 0;
        if (t == top)
        begin
            cidx = NPTS - 2;
            frac = 65536;
        end
        else
        begin
            cidx = int'(t >> 16);
            frac = t & 65535;
        end
        return 1;
    endfunction

    function automatic int corner_addr(input int cidx [AXES], input int k);
        int a;
        int addr;
        addr = 0;
        for (a = 0; a < AXES; a++)
            addr = addr * NPTS + cidx[a] + ((k >> (AXES - 1 - a)) & 1);
        return addr & ((1 << ADDR_W) - 1);
    endfunction

    function automatic int blend(input int v0, input int v1, input longint f);
        longint p;
        p = longint'(v1 - v0) * f;
        return v0 + int'((p + 32768) >>> 16);
    endfunction

    function automatic sample_t interpolate(input request_t r);
        int cidx [AXES];
        longint frac [AXES];
        int vals [32];
        bit ok;
        int a, k, n;
        sample_t s;
        ok = 1;
        for (a = 0; a < AXES; a++)
            if (!axis_locate(r.coord[AXES-1-a], grid_cfg[a], cidx[a], frac[a]))
                ok = 0;
        if (!ok)
        begin
            s.value = '0;
            s.flag = 1;
            return s;
        end
        for (k = 0; k < 32; k++)
            vals[k] = int'($signed(table_model[corner_addr(cidx, k)]));
        n = 32;
        for (a = AXES - 1; a >= 0; a--)
        begin
            n = n >> 1;
            for (k = 0; k < n; k++)
                vals[k] = blend(vals[2*k], vals[2*k+1], frac[a]);
        end
        s.value = vals[0][VAL_W-1:0];
        s.flag = 0;
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            gap = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (cur.kind == 0)
                begin
                    table_model[cur.addr] = cur.value;
                    n_writes++;
                end
                else
                begin
                    expected_q.push_back(interpolate(cur));
                    n_queries++;
                end
                gap = pick_gap();
            end
            if (!start || !busy)
            begin
                if (gap > 0)
                begin
                    gap--;
                    start <= 0;
                end
                else if (request_q.size() > 0)
                begin
                    cur = request_q.pop_front();
                    kind <= cur.kind;
                    entry_address <= cur.addr;
                    entry_value <= cur.value;
                    coord_a0 <= cur.coord[4];
                    coord_a1 <= cur.coord[3];
                    coord_a2 <= cur.coord[2];
                    coord_a3 <= cur.coord[1];
                    coord_w <= cur.coord[0];
                    start <= 1;
                end
                else
                    start <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sample_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: interp_value %0d out_of_range %0b",
                       interp_value, out_of_range);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.flag)
                    n_oor++;
                if (interp_value !== e.value)
                begin
                    $error("interp_value: expected %0d, got %0d", $signed(e.value),
                           interp_value);
                    errors++;
                end
                if (out_of_range !== e.flag)
                begin
                    $error("out_of_range: expected %0b, got %0b", e.flag, out_of_range);
                    errors++;
                end
            end
        end
    end

    function automatic request_t rand_request(input logic k);
        request_t r;
        r.kind = k;
        r.addr = ADDR_W'($urandom);
        r.value = VAL_W'($urandom);
        r.coord = (AXES * VAL_W)'({$urandom, $urandom, $urandom});
        return r;
    endfunction

    function automatic void add_write(input int addr, input logic [VAL_W-1:0] v);
        request_t r;
        r = rand_request(0);
        r.addr = ADDR_W'(addr);
        r.value = v;
        written[addr] = 1;
        request_q.push_back(r);
        phase_count++;
    endfunction

    // coords given as axis0..w; for an in-range query, corners not yet loaded get written first
    function automatic void add_query(input logic [VAL_W-1:0] c [AXES]);
        request_t r;
        int cidx [AXES];
        longint frac [AXES];
        bit ok;
        int a, k, addr;
        r = rand_request(1);
        ok = 1;
        for (a = 0; a < AXES; a++)
        begin
            r.coord[AXES-1-a] = c[a];
            if (!axis_locate(c[a], grid_cfg[a], cidx[a], frac[a]))
                ok = 0;
        end
        if (ok)
            for (k = 0; k < 32; k++)
            begin
                addr = corner_addr(cidx, k);
                if (!written[addr])
                    add_write(addr, VAL_W'($urandom));
            end
        request_q.push_back(r);
        phase_count++;
    endfunction

    function automatic logic [VAL_W-1:0] pick_coord(input logic [CFG_W-1:0] g);
        int o, r, dmax, hi;
        o = int'($signed(g[31:16]));
        r = int'(g[15:0]);
        if ($urandom_range(0, 9) == 0)
            return VAL_W'($urandom);
        if ($urandom_range(0, 19) == 0 && o > -32768)
            return VAL_W'(o - 1);
        dmax = (r == 0) ? 32767 - o : ((NPTS - 1) * 65536) / r;
        hi = o + dmax;
        if (hi > 32767)
            hi = 32767;
        if ($urandom_range(0, 7) == 0)
            return VAL_W'(hi);
        return VAL_W'(o + int'($urandom_range(0, hi - o)));
    endfunction

    task automatic program_axes(input logic [CFG_W-1:0] g [AXES]);
        int i;
        for (i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we <= 1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= (i < AXES) ? g[i] : $urandom;
            if (i < AXES)
                grid_cfg[i] = g[i];
        end
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (request_q.size() > 0 || start || expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase();
        logic [VAL_W-1:0] c [AXES];
        int a;
        while (phase_count < PHASE_WORDS)
        begin
            if ($urandom_range(0, 99) < 15)
                add_write($urandom_range(0, (1 << ADDR_W) - 1), VAL_W'($urandom));
            else
            begin
                for (a = 0; a < AXES; a++)
                    c[a] = pick_coord(grid_cfg[a]);
                add_query(c);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] g [AXES];
        int a, ph;
        for (a = 0; a < AXES; a++)
            grid_cfg[a] = GRID_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // directed, reset grid: points at 0, 1.0 .. 7.0
        phase_count = 0;
        add_write(0, 16'h7FFF);
        add_write(1, 16'h8000);
        add_query('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        add_query('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0080});
        add_query('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001});
        add_query('{16'h0700, 16'h0700, 16'h0700, 16'h0700, 16'h0700});
        add_query('{16'h0700, 16'h0000, 16'h06FF, 16'h0380, 16'h0700});
        add_query('{16'hFFFF, 16'h0100, 16'h0100, 16'h0100, 16'h0100});
        add_query('{16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0701});
        add_query('{16'h7FFF, 16'h0100, 16'h0100, 16'h0100, 16'h0100});
        add_query('{16'h0100, 16'h8000, 16'h0100, 16'h0100, 16'h0100});
        add_query('{16'h0155, 16'h02AA, 16'h0333, 16'h04CC, 16'h05FF});
        random_phase();

        for (ph = 1; ph < 5; ph++)
        begin
            drain();
            for (a = 0; a < AXES; a++)
                case (ph)
                    1: g[a] = GRID_RESET;
                    2: g[a] = {16'($urandom_range(0, 1024) - 512), 16'($urandom_range(32, 1024))};
                    default: g[a] = $urandom;
                endcase
            if (ph == 3)
            begin
                g[0] = 32'h8000_FFFF;
                g[1] = 32'h7FFF_0001;
                g[2] = 32'h0000_0000;
                g[3] = 32'h8000_0001;
                g[4] = 32'hFFFF_0100;
            end
            program_axes(g);
            phase_count = 0;
            random_phase();
        end
        drain();

        if (expected_q.size() > 0)
        begin
            $error("%0d expected words never arrived", expected_q.size());
            errors++;
        end
        $display("Covered %0d table writes and %0d queries (%0d out of range) over 5 grid setups.",
                 n_writes, n_queries, n_oor);
        if (errors == 0)
            $display("** grid_multilinear_interp_5d: PASSED **");
        else
            $display("** grid_multilinear_interp_5d: FAILED **");
        $finish;
    end
endmodule
